// File: hw/rtl/cbe_pkg.sv
// Shared widths, register indexes and types of the cubic Bezier evaluator.
`default_nettype none

package cbe_pkg;

  localparam int T_W        = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int COORD_W    = 16;
  localparam int SLOPE_W    = 19;
  localparam int BEND_W     = 21;
  localparam int PIPE_DEPTH = 7;

  localparam logic [T_W-1:0] T_ONE = T_W'(65536);

  localparam logic [CFG_IDX_W-1:0] REG_CTRL0_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL0_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL1_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL1_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL2_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL2_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL3_X = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL3_Y = 3'd7;

  // The four control point coordinates of one axis.
  typedef struct packed {
    logic signed [COORD_W-1:0] p0;
    logic signed [COORD_W-1:0] p1;
    logic signed [COORD_W-1:0] p2;
    logic signed [COORD_W-1:0] p3;
  } ctrl_pts_t;

  // Rounded results of one axis.
  typedef struct packed {
    logic [COORD_W-1:0] point;
    logic [SLOPE_W-1:0] slope;
    logic [BEND_W-1:0]  bend;
  } axis_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/cubic_bezier_evaluator_top.sv
// Top level of the cubic Bezier evaluator: control registers, input clamp and valid pipeline.
// Pipeline: a transaction passes through seven register stages before its result shows on the outputs
// (the stage count is set by the three chained multiplications of the Horner scheme).
// Throughput: one transaction per clock cycle; busy is low except during reset and in the cycle after it.
// Reset: rst_n is synchronous and active low; it empties the pipeline and restores the control
// points to (0,0), (0,1), (0,2), (0,3). The receiver cannot stall, so results are never held.
`default_nettype none

module cubic_bezier_evaluator_top import cbe_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [T_W-1:0]         in_param_t,
  output logic                   out_valid,
  output logic signed [COORD_W-1:0] out_point_x,
  output logic signed [COORD_W-1:0] out_point_y,
  output logic signed [SLOPE_W-1:0] out_slope_x,
  output logic signed [SLOPE_W-1:0] out_slope_y,
  output logic signed [BEND_W-1:0]  out_bend_x,
  output logic signed [BEND_W-1:0]  out_bend_y,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic signed [COORD_W-1:0] ctrl0_x_r, ctrl0_y_r, ctrl1_x_r, ctrl1_y_r;
  logic signed [COORD_W-1:0] ctrl2_x_r, ctrl2_y_r, ctrl3_x_r, ctrl3_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl0_x_r <= 16'sd0;
      ctrl0_y_r <= 16'sd0;
      ctrl1_x_r <= 16'sd0;
      ctrl1_y_r <= 16'sd1;
      ctrl2_x_r <= 16'sd0;
      ctrl2_y_r <= 16'sd2;
      ctrl3_x_r <= 16'sd0;
      ctrl3_y_r <= 16'sd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CTRL0_X: ctrl0_x_r <= $signed(cfg_wdata);
        REG_CTRL0_Y: ctrl0_y_r <= $signed(cfg_wdata);
        REG_CTRL1_X: ctrl1_x_r <= $signed(cfg_wdata);
        REG_CTRL1_Y: ctrl1_y_r <= $signed(cfg_wdata);
        REG_CTRL2_X: ctrl2_x_r <= $signed(cfg_wdata);
        REG_CTRL2_Y: ctrl2_y_r <= $signed(cfg_wdata);
        REG_CTRL3_X: ctrl3_x_r <= $signed(cfg_wdata);
        REG_CTRL3_Y: ctrl3_y_r <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  logic                  busy_r;
  logic                  accept;
  logic [PIPE_DEPTH-1:0] valid_r, valid_nxt;
  logic [T_W-1:0]        t_clamp;

  assign busy   = busy_r | ~rst_n;
  assign accept = start & ~busy;

  // Anything above one is taken as exactly one.
  assign t_clamp = (in_param_t > T_ONE) ? T_ONE : in_param_t;

  assign valid_nxt = {valid_r[PIPE_DEPTH-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      valid_r <= '0;
    end else begin
      busy_r  <= 1'b0;
      valid_r <= valid_nxt;
    end
  end

  ctrl_pts_t pts_x, pts_y;
  axis_res_t res_x, res_y;

  assign pts_x = '{p0: ctrl0_x_r, p1: ctrl1_x_r, p2: ctrl2_x_r, p3: ctrl3_x_r};
  assign pts_y = '{p0: ctrl0_y_r, p1: ctrl1_y_r, p2: ctrl2_y_r, p3: ctrl3_y_r};

  cbe_axis u_axis_x (
    .clk  (clk),
    .t_in (t_clamp),
    .pts  (pts_x),
    .res  (res_x)
  );

  cbe_axis u_axis_y (
    .clk  (clk),
    .t_in (t_clamp),
    .pts  (pts_y),
    .res  (res_y)
  );

  assign out_valid   = valid_r[PIPE_DEPTH-1];
  assign out_point_x = $signed(res_x.point);
  assign out_point_y = $signed(res_y.point);
  assign out_slope_x = $signed(res_x.slope);
  assign out_slope_y = $signed(res_y.slope);
  assign out_bend_x  = $signed(res_x.bend);
  assign out_bend_y  = $signed(res_y.bend);

endmodule

`default_nettype wire

// File: hw/rtl/cbe_axis.sv
// Seven-stage Horner pipeline that evaluates one axis of the curve and its derivatives.
`default_nettype none

module cbe_axis import cbe_pkg::*; (
  input  logic            clk,
  input  logic [T_W-1:0]  t_in,
  input  ctrl_pts_t       pts,
  output axis_res_t       res
);

  // Power basis coefficients, recomputed every cycle from the control points.
  logic signed [20:0] e0, e1, e2, e3;
  logic signed [15:0] c0_r, c0_nxt;
  logic signed [18:0] c1_r, c1_nxt;
  logic signed [19:0] c2_r, c2_nxt;
  logic signed [18:0] c3_r, c3_nxt;

  assign e0 = 21'($signed(pts.p0));
  assign e1 = 21'($signed(pts.p1));
  assign e2 = 21'($signed(pts.p2));
  assign e3 = 21'($signed(pts.p3));

  always_comb begin
    c0_nxt = $signed(pts.p0);
    c1_nxt = 19'(3 * (e1 - e0));
    c2_nxt = 20'(3 * (e0 - 2 * e1 + e2));
    c3_nxt = 19'(e3 - 3 * e2 + 3 * e1 - e0);
  end

  always_ff @(posedge clk) begin
    c0_r <= c0_nxt;
    c1_r <= c1_nxt;
    c2_r <= c2_nxt;
    c3_r <= c3_nxt;
  end

  logic [T_W-1:0] t1_r, t2_r, t3_r, t4_r, t5_r;

  logic signed [36:0] m_r, m_nxt;
  logic signed [36:0] h1_r, h1_nxt;
  logic signed [37:0] g_r, g_nxt;
  logic signed [39:0] bend_sum;
  logic [BEND_W-1:0]  bend3_r, bend4_r, bend5_r, bend6_r, bend7_r, bend_nxt;

  logic [36:0]        h1lo_r, h1lo_nxt;
  logic signed [34:0] h1hi_r, h1hi_nxt;
  logic [36:0]        glo_r, glo_nxt;
  logic signed [35:0] ghi_r, ghi_nxt;

  logic signed [53:0] h2_r, h2_nxt;
  logic [50:0]        slope_sum;
  logic [SLOPE_W-1:0] slope5_r, slope6_r, slope7_r, slope_nxt;

  logic [43:0]        h2lo_r, h2lo_nxt;
  logic signed [44:0] h2hi_r, h2hi_nxt;

  logic [63:0]        point_sum;
  logic [COORD_W-1:0] point7_r, point_nxt;

  // The wide products are split at a fixed bit so that each multiplier stays narrow;
  // the sums are taken modulo a power of two that still covers the output bits.
  always_comb begin
    m_nxt    = c3_r * $signed({1'b0, t1_r});

    h1_nxt   = m_r + (37'(c2_r) <<< 16);
    g_nxt    = 3 * 38'(m_r) + (38'(c2_r) <<< 17);
    bend_sum = 6 * 40'(m_r) + (40'(c2_r) <<< 17) + (40'sd1 <<< 15);
    bend_nxt = bend_sum[36:16];

    h1lo_nxt = h1_r[19:0] * t3_r;
    h1hi_nxt = $signed(h1_r[36:20]) * $signed({1'b0, t3_r});
    glo_nxt  = g_r[19:0] * t3_r;
    ghi_nxt  = $signed(g_r[37:20]) * $signed({1'b0, t3_r});

    h2_nxt    = (54'(h1hi_r) <<< 20) + 54'(h1lo_r) + (54'(c1_r) <<< 32);
    slope_sum = (51'(ghi_r) << 20) + 51'(glo_r) + (51'(c1_r) << 32) + (51'(1) << 31);
    slope_nxt = slope_sum[50:32];

    h2lo_nxt = h2_r[26:0] * t5_r;
    h2hi_nxt = $signed(h2_r[53:27]) * $signed({1'b0, t5_r});

    point_sum = (64'(h2hi_r) << 27) + 64'(h2lo_r) + (64'(c0_r) << 48) + (64'(1) << 47);
    point_nxt = point_sum[63:48];
  end

  always_ff @(posedge clk) begin
    t1_r     <= t_in;
    t2_r     <= t1_r;
    t3_r     <= t2_r;
    t4_r     <= t3_r;
    t5_r     <= t4_r;

    m_r      <= m_nxt;

    h1_r     <= h1_nxt;
    g_r      <= g_nxt;
    bend3_r  <= bend_nxt;

    h1lo_r   <= h1lo_nxt;
    h1hi_r   <= h1hi_nxt;
    glo_r    <= glo_nxt;
    ghi_r    <= ghi_nxt;
    bend4_r  <= bend3_r;

    h2_r     <= h2_nxt;
    slope5_r <= slope_nxt;
    bend5_r  <= bend4_r;

    h2lo_r   <= h2lo_nxt;
    h2hi_r   <= h2hi_nxt;
    slope6_r <= slope5_r;
    bend6_r  <= bend5_r;

    point7_r <= point_nxt;
    slope7_r <= slope6_r;
    bend7_r  <= bend6_r;
  end

  // The fourth copy of t is only there to line t up with the stage-five sum h2_r.
  assign res.point = point7_r;
  assign res.slope = slope7_r;
  assign res.bend  = bend7_r;

endmodule

`default_nettype wire

// File: hw/rtl/cbe_checker.sv
// Port-level checker for the cubic Bezier evaluator and its bind to the top level.
`default_nettype none

module cbe_port_checker import cbe_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input logic                   out_valid,
  input logic signed [SLOPE_W-1:0] out_slope_x,
  input logic signed [SLOPE_W-1:0] out_slope_y,
  input logic signed [BEND_W-1:0]  out_bend_x,
  input logic signed [BEND_W-1:0]  out_bend_y
);

  // Every result comes from a transaction that entered the valid pipeline earlier.
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result without a matching transaction");

  a_busy_after_reset: assert property (@(posedge clk)
    !$past(rst_n) |-> busy)
    else $error("busy low right after reset");

  a_busy_clears: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy high after reset has ended");

  // The first derivative of a curve inside the 16-bit square stays within three spans.
  a_slope_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_slope_x >= -19'sd196605 && out_slope_x <= 19'sd196605 &&
                   out_slope_y >= -19'sd196605 && out_slope_y <= 19'sd196605))
    else $error("first derivative out of range");

  a_bend_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bend_x >= -21'sd786432 && out_bend_x <= 21'sd786432 &&
                   out_bend_y >= -21'sd786432 && out_bend_y <= 21'sd786432))
    else $error("second derivative out of range");

endmodule

bind cubic_bezier_evaluator_top cbe_port_checker u_cbe_checker (.*);

`default_nettype wire

// File: tb/cbe_checker.sv
// Checker for the cubic Bezier evaluator: predicts each curve sample and compares the results.
`default_nettype none

module cbe_checker import cbe_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic [T_W-1:0]            in_param_t,
  input  logic                      out_valid,
  input  logic signed [COORD_W-1:0] out_point_x,
  input  logic signed [COORD_W-1:0] out_point_y,
  input  logic signed [SLOPE_W-1:0] out_slope_x,
  input  logic signed [SLOPE_W-1:0] out_slope_y,
  input  logic signed [BEND_W-1:0]  out_bend_x,
  input  logic signed [BEND_W-1:0]  out_bend_y,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata,
  output int                        fail_count,
  output int                        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    axis_res_t x;
    axis_res_t y;
  } curve_sample_t;

  // Wide enough that no weighted sum can overflow.
  typedef logic signed [95:0] wide_t;

  ctrl_pts_t     ctrl_x;
  ctrl_pts_t     ctrl_y;
  curve_sample_t expected_samples[$];
  curve_sample_t oldest;

  // Floor of (s / 2^shift + 1/2), which rounds ties towards plus infinity.
  function automatic wide_t round_half_up(wide_t s, int shift);
    return (s + (wide_t'(1) <<< (shift - 1))) >>> shift;
  endfunction

  function automatic axis_res_t eval_axis(ctrl_pts_t c, wide_t t, wide_t u);
    wide_t     p0, p1, p2, p3, pt, d1, d2;
    axis_res_t r;
    p0 = $signed(c.p0);
    p1 = $signed(c.p1);
    p2 = $signed(c.p2);
    p3 = $signed(c.p3);
    // Point at scale 2^48, first derivative at 2^32, second derivative at 2^16.
    pt = u * u * u * p0 + 3 * u * u * t * p1 + 3 * u * t * t * p2 + t * t * t * p3;
    d1 = 3 * (u * u * (p1 - p0) + 2 * u * t * (p2 - p1) + t * t * (p3 - p2));
    d2 = 6 * (u * (p2 - 2 * p1 + p0) + t * (p3 - 2 * p2 + p1));
    r.point = COORD_W'(round_half_up(pt, 48));
    r.slope = SLOPE_W'(round_half_up(d1, 32));
    r.bend  = BEND_W'(round_half_up(d2, 16));
    return r;
  endfunction

  function automatic curve_sample_t eval_curve(logic [T_W-1:0] raw_t);
    wide_t         t, u;
    curve_sample_t s;
    t = (raw_t > T_ONE) ? T_ONE : raw_t;
    u = T_ONE - t;
    s.x = eval_axis(ctrl_x, t, u);
    s.y = eval_axis(ctrl_y, t, u);
    return s;
  endfunction

  task automatic check_field(string fname, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_samples.delete();
      fail_count = 0;
      outstanding <= 0;
      ctrl_x <= '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
      ctrl_y <= '{16'sd0, 16'sd1, 16'sd2, 16'sd3};
    end else begin
      // Results are compared before the new transaction is queued, so a result can never be
      // matched against a prediction made at the same edge.
      if (out_valid) begin
        if (expected_samples.size() == 0) begin
          $error("result with no transaction outstanding");
          fail_count++;
        end else begin
          oldest = expected_samples.pop_front();
          check_field("point_x", $signed(oldest.x.point), out_point_x);
          check_field("point_y", $signed(oldest.y.point), out_point_y);
          check_field("slope_x", $signed(oldest.x.slope), out_slope_x);
          check_field("slope_y", $signed(oldest.y.slope), out_slope_y);
          check_field("bend_x", $signed(oldest.x.bend), out_bend_x);
          check_field("bend_y", $signed(oldest.y.bend), out_bend_y);
        end
      end
      if (start && !busy) begin
        expected_samples.insert(expected_samples.size(), eval_curve(in_param_t));
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_CTRL0_X: ctrl_x.p0 <= cfg_wdata;
          REG_CTRL0_Y: ctrl_y.p0 <= cfg_wdata;
          REG_CTRL1_X: ctrl_x.p1 <= cfg_wdata;
          REG_CTRL1_Y: ctrl_y.p1 <= cfg_wdata;
          REG_CTRL2_X: ctrl_x.p2 <= cfg_wdata;
          REG_CTRL2_Y: ctrl_y.p2 <= cfg_wdata;
          REG_CTRL3_X: ctrl_x.p3 <= cfg_wdata;
          REG_CTRL3_Y: ctrl_y.p3 <= cfg_wdata;
          default: ;
        endcase
      end
      outstanding <= expected_samples.size();
    end
  end

endmodule

`default_nettype wire

// File: tb/tb.sv
// Testbench top for the cubic Bezier evaluator: clock, reset, stimulus and verdict.
`default_nettype none

module tb import cbe_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 100000;
  localparam int ITEMS_PER_PHASE = 60;
  localparam int NUM_PHASES      = 8;

  logic                      clk         = 1'b0;
  logic                      rst_n       = 1'b0;
  logic                      start       = 1'b0;
  logic                      busy;
  logic [T_W-1:0]            in_param_t  = '0;
  logic                      out_valid;
  logic signed [COORD_W-1:0] out_point_x;
  logic signed [COORD_W-1:0] out_point_y;
  logic signed [SLOPE_W-1:0] out_slope_x;
  logic signed [SLOPE_W-1:0] out_slope_y;
  logic signed [BEND_W-1:0]  out_bend_x;
  logic signed [BEND_W-1:0]  out_bend_y;
  logic                      cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index   = '0;
  logic [CFG_DATA_W-1:0]     cfg_wdata   = '0;

  int fail_count;
  int outstanding;
  int cycle_count  = 0;
  bit quiet_sender = 1'b0;

  logic [T_W-1:0] reset_params[13] = '{0, 1, 2, 16384, 21845, 32768, 43691, 49152,
                                       65535, 65536, 65537, 98304, 131071};
  logic [T_W-1:0] corner_params[4] = '{0, 32768, 65536, 131071};

  cubic_bezier_evaluator_top i_dut (.*);
  cbe_checker i_checker (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic idle_cycles(int n);
    start <= 1'b0;
    in_param_t <= T_W'($urandom);
    repeat (n) @(posedge clk);
  endtask

  task automatic send_param(logic [T_W-1:0] t);
    start <= 1'b1;
    in_param_t <= t;
    do @(posedge clk); while (busy);
    if (!quiet_sender && $urandom_range(0, 99) < 10) begin
      idle_cycles($urandom_range(1, 4));
    end
  endtask

  // Waits until every transaction has produced its result and the pipeline has emptied.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_curve(ctrl_pts_t xs, ctrl_pts_t ys);
    write_reg(REG_CTRL0_X, xs.p0);
    write_reg(REG_CTRL0_Y, ys.p0);
    write_reg(REG_CTRL1_X, xs.p1);
    write_reg(REG_CTRL1_Y, ys.p1);
    write_reg(REG_CTRL2_X, xs.p2);
    write_reg(REG_CTRL2_Y, ys.p2);
    write_reg(REG_CTRL3_X, xs.p3);
    write_reg(REG_CTRL3_Y, ys.p3);
    cfg_we <= 1'b0;
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(posedge clk);
  endtask

  function automatic logic [T_W-1:0] pick_param();
    case ($urandom_range(0, 9))
      0: return T_W'($urandom);
      1: return T_ONE + T_W'($urandom_range(0, 65535));
      2: return T_ONE - T_W'($urandom_range(0, 15));
      3: return T_W'($urandom_range(0, 15));
      default: return T_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return COORD_W'($urandom_range(0, 8)) - 16'sd4;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic ctrl_pts_t pick_axis();
    return '{pick_coord(), pick_coord(), pick_coord(), pick_coord()};
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // The reset control points give a tie at t = 0.5 on the y axis.
    foreach (reset_params[i]) send_param(reset_params[i]);
    settle();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: load_curve('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768},
                      '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767});
        // Alternating extremes give the largest first and second derivatives.
        1: load_curve('{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767},
                      '{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768});
        2: load_curve('{16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767},
                      '{-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768});
        default: load_curve(pick_axis(), pick_axis());
      endcase
      if (phase < 3) begin
        foreach (corner_params[i]) send_param(corner_params[i]);
      end
      quiet_sender = (phase == 4);
      repeat (ITEMS_PER_PHASE) send_param(pick_param());
      settle();
    end

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
